// ===== rtl/point_local_frame_projection_defines.svh =====
// Assertion macros used by the local frame projection top level
`ifndef POINT_LOCAL_FRAME_PROJECTION_DEFINES_SVH
`define POINT_LOCAL_FRAME_PROJECTION_DEFINES_SVH
`ifndef SYNTH
// checked outside reset
`define PLFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked in every cycle, reset included
`define PLFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLFP_ASSERT(lbl, prop, msg)
`define PLFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/plfp_pkg.sv =====
// Package: widths, latencies and helpers of the local frame projection
package plfp_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int UV_W      = 18;   // Q2.16 unit vector component, signed
  localparam int FRAC      = 16;
  localparam int NRM_W     = 30;   // magnitudes below 2^30 before squaring
  localparam int SQ_N      = 31;   // root bits of the integer square root
  localparam int DIV_N     = 17;   // quotient bits of the normalising divide
  localparam int UNIT_LAT  = 4 + SQ_N + 1 + DIV_N;
  localparam int CROSS_LIM = 31;   // cross operands kept below 2^31
  localparam int XW        = CROSS_LIM + 1;
  localparam int WW        = 2 * XW;
  localparam int WMW       = WW - 1;

  // Right shift that brings the largest magnitude (OR of all) below 2^lim
  function automatic logic [6:0] shr_amt(input logic [63:0] orv, input logic [6:0] lim);
    logic [6:0] msb;
    msb = '0;
    for (int i = 0; i < 64; i++) begin
      if (orv[i]) msb = 7'(i + 1);
    end
    return (msb > lim) ? 7'(msb - lim) : 7'd0;
  endfunction

endpackage

// ===== rtl/plfp_unit.sv =====
// Pipelined unit vector: shrink, square sum, integer root, rounded divide
module plfp_unit #(
  parameter int MW = 33
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [MW-1:0]                         mag_i [3],
  input  logic [2:0]                            neg_i,
  output logic signed [plfp_pkg::UV_W-1:0]      vec_o [3],
  output logic                                  zero_o
);

  localparam int SQ_N  = plfp_pkg::SQ_N;
  localparam int DIV_N = plfp_pkg::DIV_N;
  localparam int NW    = plfp_pkg::NRM_W;
  localparam int RW    = 2 * SQ_N;          // radicand and root work width
  localparam int LW    = SQ_N;              // final root (length) width
  localparam int QW    = DIV_N;
  localparam int NUMW  = NW + plfp_pkg::FRAC + 1;

  // shrink
  logic [MW-1:0]  mag0_r [3];
  logic [2:0]     neg0_r;
  logic [6:0]     sh0_r;
  logic [NW-1:0]  m1_r [3];
  logic [2:0]     neg1_r;
  // squares and sum
  logic [2*NW-1:0] sq2_r [3];
  logic [NW-1:0]   m2_r [3];
  logic [2:0]      neg2_r;
  logic            zero2_r;
  logic [RW-1:0]   n2_r;
  logic [NW-1:0]   m3_r [3];
  logic [2:0]      neg3_r;
  logic            zero3_r;
  // root, one bit a stage
  logic [RW-1:0]  rem_r  [SQ_N];
  logic [RW-1:0]  root_r [SQ_N];
  logic [NW-1:0]  sm_r   [SQ_N][3];
  logic [2:0]     sneg_r [SQ_N];
  logic           szero_r [SQ_N];
  logic [RW-1:0]  rem_nxt  [SQ_N];
  logic [RW-1:0]  root_nxt [SQ_N];
  // numerator set-up
  logic [NW-1:0]  nh_r [3];
  logic [QW-1:0]  nl_r [3];
  logic [LW-1:0]  len_r;
  logic [2:0]     nneg_r;
  logic           nzero_r;
  // divide, one quotient bit a stage
  logic [LW-1:0]  dr_r  [DIV_N][3];
  logic [QW-1:0]  dlo_r [DIV_N][3];
  logic [QW-1:0]  dq_r  [DIV_N][3];
  logic [LW-1:0]  dlen_r [DIV_N];
  logic [2:0]     dneg_r [DIV_N];
  logic           dzero_r [DIV_N];
  logic [LW-1:0]  dr_nxt [DIV_N][3];
  logic [QW-1:0]  dq_nxt [DIV_N][3];

  logic [6:0]     sh_nxt;
  logic [NUMW-1:0] num_nxt [3];

  always_comb begin
    sh_nxt = plfp_pkg::shr_amt(64'(mag_i[0] | mag_i[1] | mag_i[2]), 7'(NW));
    for (int k = 0; k < 3; k++) begin
      num_nxt[k] = (NUMW'(sm_r[SQ_N-1][k]) << plfp_pkg::FRAC)
                 + NUMW'(root_r[SQ_N-1] >> 1);
    end
  end

  always_comb begin
    logic [RW-1:0] r_in, n_in, bitv;
    r_in = '0;
    n_in = '0;
    bitv = '0;
    for (int t = 0; t < SQ_N; t++) begin
      n_in = (t == 0) ? n2_r : rem_r[t-1];
      r_in = (t == 0) ? '0   : root_r[t-1];
      bitv = RW'(1) << (2 * (SQ_N - 1 - t));
      if (n_in >= r_in + bitv) begin
        rem_nxt[t]  = n_in - (r_in + bitv);
        root_nxt[t] = (r_in >> 1) + bitv;
      end else begin
        rem_nxt[t]  = n_in;
        root_nxt[t] = r_in >> 1;
      end
    end
  end

  always_comb begin
    logic [LW:0]   tr;
    logic [LW-1:0] rin, len;
    logic [QW-1:0] lo, qin;
    tr  = '0;
    rin = '0;
    len = '0;
    lo  = '0;
    qin = '0;
    for (int t = 0; t < DIV_N; t++) begin
      for (int k = 0; k < 3; k++) begin
        rin = (t == 0) ? LW'(nh_r[k]) : dr_r[t-1][k];
        lo  = (t == 0) ? nl_r[k]      : dlo_r[t-1][k];
        qin = (t == 0) ? '0           : dq_r[t-1][k];
        len = (t == 0) ? len_r        : dlen_r[t-1];
        tr  = {rin, lo[DIV_N-1-t]};
        if (tr >= {1'b0, len}) begin
          dr_nxt[t][k] = LW'(tr - {1'b0, len});
          dq_nxt[t][k] = {qin[QW-2:0], 1'b1};
        end else begin
          dr_nxt[t][k] = LW'(tr);
          dq_nxt[t][k] = {qin[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0_r <= mag_i;
      neg0_r <= neg_i;
      sh0_r  <= sh_nxt;
      neg1_r <= neg0_r;
      neg2_r <= neg1_r;
      neg3_r <= neg2_r;
      zero2_r <= (m1_r[0] == '0) && (m1_r[1] == '0) && (m1_r[2] == '0);
      zero3_r <= zero2_r;
      n2_r <= RW'(sq2_r[0]) + RW'(sq2_r[1]) + RW'(sq2_r[2]);
      for (int k = 0; k < 3; k++) begin
        m1_r[k]  <= NW'(mag0_r[k] >> sh0_r);
        sq2_r[k] <= (2*NW)'(m1_r[k]) * (2*NW)'(m1_r[k]);
        m2_r[k]  <= m1_r[k];
        m3_r[k]  <= m2_r[k];
        nh_r[k]  <= NW'(num_nxt[k] >> QW);
        nl_r[k]  <= num_nxt[k][QW-1:0];
      end
      for (int t = 0; t < SQ_N; t++) begin
        rem_r[t]   <= rem_nxt[t];
        root_r[t]  <= root_nxt[t];
        sm_r[t]    <= (t == 0) ? m3_r    : sm_r[t-1];
        sneg_r[t]  <= (t == 0) ? neg3_r  : sneg_r[t-1];
        szero_r[t] <= (t == 0) ? zero3_r : szero_r[t-1];
      end
      len_r   <= LW'(root_r[SQ_N-1]);
      nneg_r  <= sneg_r[SQ_N-1];
      nzero_r <= szero_r[SQ_N-1];
      for (int t = 0; t < DIV_N; t++) begin
        dr_r[t]    <= dr_nxt[t];
        dq_r[t]    <= dq_nxt[t];
        dlo_r[t]   <= (t == 0) ? nl_r    : dlo_r[t-1];
        dlen_r[t]  <= (t == 0) ? len_r   : dlen_r[t-1];
        dneg_r[t]  <= (t == 0) ? nneg_r  : dneg_r[t-1];
        dzero_r[t] <= (t == 0) ? nzero_r : dzero_r[t-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_o[k] = dneg_r[DIV_N-1][k] ? -plfp_pkg::UV_W'(dq_r[DIV_N-1][k])
                                    :  plfp_pkg::UV_W'(dq_r[DIV_N-1][k]);
    end
  end
  assign zero_o = dzero_r[DIV_N-1];

endmodule

// ===== rtl/point_local_frame_projection.sv =====
// Top level: orthonormal frame from three points, point projected into or out of it
//
//  channel | ports                       | beat contents
//  input   | in_tvalid/in_tready/in_tdata | four points a, b, c, p
//  result  | out_tvalid/out_tready/out_*  | res_x, res_y, res_z, degenerate
//  config  | cfg_wr_en/cfg_wr_data        | inverse_mode
//
// One beat in and one out per cycle while the result side is not stalled; the latency is set by the
// one-bit-a-stage integer root (31 stages) and normalising divide (17 stages).
// Reset (rst_n low, synchronous) empties the pipeline and clears inverse_mode.
// A stalled result stalls the whole pipeline in place; nothing is dropped.
`include "point_local_frame_projection_defines.svh"
module point_local_frame_projection #(
  parameter int COORD_BITS = plfp_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // org_x, org_y, org_z, axis_x, axis_y, axis_z, plane_x, plane_y, plane_z,
  // pt_x, pt_y, pt_z
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // res_x, res_y, res_z
  output logic [((3*COORD_BITS+7)/8)*8-1:0]         out_tdata,
  // degenerate
  output logic                                      out_tuser,
  input  logic                                      cfg_wr_en,
  input  logic                                      cfg_wr_data
);

  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((3*CB+7)/8)*8;
  localparam int DW    = CB + 1;
  localparam int UV    = plfp_pkg::UV_W;
  localparam int FR    = plfp_pkg::FRAC;
  localparam int XW    = plfp_pkg::XW;
  localparam int WW    = plfp_pkg::WW;
  localparam int WMW   = plfp_pkg::WMW;
  localparam int PRW   = DW + UV;
  localparam int SMW   = PRW + 2;
  localparam int RNW   = SMW - FR;
  localparam int OW    = RNW + 1;
  localparam int VPW   = 2 * UV;
  localparam int SBW   = 3 * DW + 6 * CB;
  localparam int U_OUT = 4 + plfp_pkg::UNIT_LAT;  // stage holding unit results
  localparam int ST_G  = U_OUT + 3;
  localparam int NST   = U_OUT + 7;
  localparam logic signed [OW-1:0] SAT_HI = OW'((longint'(1) <<< (CB-1)) - 1);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);
  localparam logic signed [UV-1:0] ONE_Q  = UV'(1 << FR);

  logic              en;
  logic [NST-1:0]    vld_r;
  logic              inv_mode_r;

  // input unpack
  logic signed [CB-1:0] a_in [3], b_in [3], c_in [3], p_in [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_in[k] = in_tdata[k*CB +: CB];
      b_in[k] = in_tdata[(3+k)*CB +: CB];
      c_in[k] = in_tdata[(6+k)*CB +: CB];
      p_in[k] = in_tdata[(9+k)*CB +: CB];
    end
  end

  // stage A..E: differences, cross product of shrunk b-a and c-a
  logic signed [DW-1:0] d_a_r [3], e_a_r [3];
  logic [SBW-1:0]       sb_r [ST_G];
  logic signed [DW-1:0] d_b_r [3], e_b_r [3];
  logic [6:0]           shd_b_r, she_b_r;
  logic signed [DW-1:0] d_c_r [3];
  logic signed [XW-1:0] dc_c_r [3], ec_c_r [3];
  logic signed [DW-1:0] d_d_r [3];
  logic signed [WW-1:0] pr_d_r [6];
  logic signed [DW-1:0] d_e_r [3];
  logic signed [WW-1:0] w_e_r [3];

  logic [DW-1:0]  dmag_a [3], emag_a [3], dmag_b [3], emag_b [3], dmag_e [3];
  logic [WMW-1:0] wmag_e [3];
  logic [2:0]     dneg_e, wneg_e;
  logic signed [DW-1:0] q_in [3];
  logic [6:0]     shd_nxt, she_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_in[k]   = DW'(p_in[k]) - DW'(a_in[k]);
      dmag_a[k] = d_a_r[k][DW-1] ? DW'(-d_a_r[k]) : DW'(d_a_r[k]);
      emag_a[k] = e_a_r[k][DW-1] ? DW'(-e_a_r[k]) : DW'(e_a_r[k]);
      dmag_b[k] = d_b_r[k][DW-1] ? DW'(-d_b_r[k]) : DW'(d_b_r[k]);
      emag_b[k] = e_b_r[k][DW-1] ? DW'(-e_b_r[k]) : DW'(e_b_r[k]);
      dmag_e[k] = d_e_r[k][DW-1] ? DW'(-d_e_r[k]) : DW'(d_e_r[k]);
      dneg_e[k] = d_e_r[k][DW-1];
      wmag_e[k] = w_e_r[k][WW-1] ? WMW'(-w_e_r[k]) : WMW'(w_e_r[k]);
      wneg_e[k] = w_e_r[k][WW-1];
    end
    shd_nxt = plfp_pkg::shr_amt(64'(dmag_a[0] | dmag_a[1] | dmag_a[2]),
                                7'(plfp_pkg::CROSS_LIM));
    she_nxt = plfp_pkg::shr_amt(64'(emag_a[0] | emag_a[1] | emag_a[2]),
                                7'(plfp_pkg::CROSS_LIM));
  end

  // unit vectors v1 = unit(b-a), v3 = unit((b-a) x (c-a))
  logic signed [UV-1:0] v1_u [3], v3_u [3];
  logic                 z1_u, z3_u;

  plfp_unit #(.MW(DW)) u_unit_v1 (
    .clk    (clk),
    .en     (en),
    .mag_i  (dmag_e),
    .neg_i  (dneg_e),
    .vec_o  (v1_u),
    .zero_o (z1_u)
  );

  plfp_unit #(.MW(WMW)) u_unit_v3 (
    .clk    (clk),
    .en     (en),
    .mag_i  (wmag_e),
    .neg_i  (wneg_e),
    .vec_o  (v3_u),
    .zero_o (z3_u)
  );

  // stages F..K
  logic signed [UV-1:0]  v1_f_r [3], v3_f_r [3];
  logic signed [VPW-1:0] pp_f_r [6];
  logic                  deg_f_r;
  logic signed [UV-1:0]  vv_g_r [3][3];
  logic                  deg_g_r;
  logic signed [PRW-1:0] pr_h_r [3][3];
  logic signed [CB-1:0]  a_h_r [3], a_i_r [3];
  logic                  deg_h_r, deg_i_r, deg_j_r;
  logic signed [SMW-1:0] sum_i_r [3];
  logic [RNW-1:0]        rnd_j_r [3];
  logic [2:0]            rneg_j_r;
  logic signed [CB-1:0]  a_j_r [3];
  logic signed [CB-1:0]  res_k_r [3];
  logic                  deg_k_r;

  logic signed [UV-1:0]  v2_nxt [3];
  logic signed [DW-1:0]  q_g [3], opd_g [3];
  logic signed [CB-1:0]  p_g [3], a_g [3];
  logic signed [UV-1:0]  mx_g [3][3];
  logic [RNW-1:0]        rnd_nxt [3];
  logic signed [CB-1:0]  res_nxt [3];

  always_comb begin
    logic signed [VPW:0] wv;
    logic [VPW:0]        wm;
    logic [VPW:0]        wr;
    logic [SMW-1:0]      sm;
    logic signed [OW-1:0] ov;
    wv = '0;
    wm = '0;
    wr = '0;
    sm = '0;
    ov = '0;
    for (int k = 0; k < 3; k++) begin
      wv = (VPW+1)'(pp_f_r[2*k]) - (VPW+1)'(pp_f_r[2*k+1]);
      wm = wv[VPW] ? (VPW+1)'(-wv) : (VPW+1)'(wv);
      wr = (wm + (VPW+1)'(1 << (FR-1))) >> FR;
      v2_nxt[k] = wv[VPW] ? -UV'(wr) : UV'(wr);
    end
    for (int k = 0; k < 3; k++) begin
      q_g[k] = sb_r[ST_G-1][k*DW +: DW];
      p_g[k] = sb_r[ST_G-1][3*DW + k*CB +: CB];
      a_g[k] = sb_r[ST_G-1][3*DW + (3+k)*CB +: CB];
      opd_g[k] = inv_mode_r ? DW'(p_g[k]) : q_g[k];
    end
    // forward takes rows of the frame, inverse its columns
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mx_g[i][j] = inv_mode_r ? vv_g_r[j][i] : vv_g_r[i][j];
      end
    end
    for (int k = 0; k < 3; k++) begin
      sm = sum_i_r[k][SMW-1] ? SMW'(-sum_i_r[k]) : SMW'(sum_i_r[k]);
      rnd_nxt[k] = RNW'((sm + SMW'(1 << (FR-1))) >> FR);
      ov = rneg_j_r[k] ? OW'(a_j_r[k]) - OW'(rnd_j_r[k])
                       : OW'(a_j_r[k]) + OW'(rnd_j_r[k]);
      if (deg_j_r) begin
        res_nxt[k] = '0;
      end else if (ov > SAT_HI) begin
        res_nxt[k] = CB'(SAT_HI);
      end else if (ov < SAT_LO) begin
        res_nxt[k] = CB'(SAT_LO);
      end else begin
        res_nxt[k] = CB'(ov);
      end
    end
  end

  assign en        = out_tready | ~vld_r[NST-1];
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      inv_mode_r <= 1'b0;
    end else begin
      if (cfg_wr_en) inv_mode_r <= cfg_wr_data;
      if (en) vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_a_r[k] <= DW'(b_in[k]) - DW'(a_in[k]);
        e_a_r[k] <= DW'(c_in[k]) - DW'(a_in[k]);
      end
      sb_r[0] <= {p_in[2], p_in[1], p_in[0], a_in[2], a_in[1], a_in[0],
                  q_in[2], q_in[1], q_in[0]} == '0 ? '0 :
                 {a_in[2], a_in[1], a_in[0], p_in[2], p_in[1], p_in[0],
                  q_in[2], q_in[1], q_in[0]};
      for (int t = 1; t < ST_G; t++) sb_r[t] <= sb_r[t-1];
      d_b_r   <= d_a_r;
      e_b_r   <= e_a_r;
      shd_b_r <= shd_nxt;
      she_b_r <= she_nxt;
      d_c_r   <= d_b_r;
      for (int k = 0; k < 3; k++) begin
        dc_c_r[k] <= d_b_r[k][DW-1] ? -XW'(dmag_b[k] >> shd_b_r) : XW'(dmag_b[k] >> shd_b_r);
        ec_c_r[k] <= e_b_r[k][DW-1] ? -XW'(emag_b[k] >> she_b_r) : XW'(emag_b[k] >> she_b_r);
      end
      d_d_r     <= d_c_r;
      pr_d_r[0] <= WW'(dc_c_r[1]) * WW'(ec_c_r[2]);
      pr_d_r[1] <= WW'(dc_c_r[2]) * WW'(ec_c_r[1]);
      pr_d_r[2] <= WW'(dc_c_r[2]) * WW'(ec_c_r[0]);
      pr_d_r[3] <= WW'(dc_c_r[0]) * WW'(ec_c_r[2]);
      pr_d_r[4] <= WW'(dc_c_r[0]) * WW'(ec_c_r[1]);
      pr_d_r[5] <= WW'(dc_c_r[1]) * WW'(ec_c_r[0]);
      d_e_r     <= d_d_r;
      for (int k = 0; k < 3; k++) w_e_r[k] <= pr_d_r[2*k] - pr_d_r[2*k+1];
      // F: v2 = v3 x v1 partial products
      v1_f_r    <= v1_u;
      v3_f_r    <= v3_u;
      deg_f_r   <= z1_u | z3_u;
      pp_f_r[0] <= VPW'(v3_u[1]) * VPW'(v1_u[2]);
      pp_f_r[1] <= VPW'(v3_u[2]) * VPW'(v1_u[1]);
      pp_f_r[2] <= VPW'(v3_u[2]) * VPW'(v1_u[0]);
      pp_f_r[3] <= VPW'(v3_u[0]) * VPW'(v1_u[2]);
      pp_f_r[4] <= VPW'(v3_u[0]) * VPW'(v1_u[1]);
      pp_f_r[5] <= VPW'(v3_u[1]) * VPW'(v1_u[0]);
      // G
      vv_g_r[0] <= v1_f_r;
      vv_g_r[1] <= v2_nxt;
      vv_g_r[2] <= v3_f_r;
      deg_g_r   <= deg_f_r;
      // H: nine products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_h_r[i][j] <= PRW'(opd_g[j]) * PRW'(mx_g[i][j]);
        end
      end
      a_h_r   <= a_g;
      deg_h_r <= deg_g_r;
      // I
      for (int i = 0; i < 3; i++) begin
        sum_i_r[i] <= SMW'(pr_h_r[i][0]) + SMW'(pr_h_r[i][1]) + SMW'(pr_h_r[i][2]);
        a_i_r[i]   <= inv_mode_r ? a_h_r[i] : '0;
      end
      deg_i_r <= deg_h_r;
      // J: round magnitude
      for (int k = 0; k < 3; k++) begin
        rnd_j_r[k]  <= rnd_nxt[k];
        rneg_j_r[k] <= sum_i_r[k][SMW-1];
      end
      a_j_r   <= a_i_r;
      deg_j_r <= deg_i_r;
      // K: offset, saturate, zero when degenerate
      res_k_r <= res_nxt;
      deg_k_r <= deg_j_r;
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tuser  = deg_k_r;
  assign out_tdata  = OUT_W'({res_k_r[2], res_k_r[1], res_k_r[0]});

  `PLFP_ASSERT(a_deg_zero, out_tvalid && out_tuser |-> out_tdata == '0, "degenerate result not zero")
  `PLFP_ASSERT(a_stall_hold, !en |=> $stable(vld_r), "pipeline moved while stalled")
  `PLFP_ASSERT(a_v1_range, vld_r[U_OUT] && !z1_u |-> (v1_u[0] <= ONE_Q && v1_u[0] >= -ONE_Q && v1_u[1] <= ONE_Q && v1_u[1] >= -ONE_Q && v1_u[2] <= ONE_Q && v1_u[2] >= -ONE_Q), "unit vector out of range")
  `PLFP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

// ===== bench/tb.sv =====
// Testbench for point_local_frame_projection: random and directed frames against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = plfp_pkg::COORD_BITS_DEF;
  localparam int IN_W = ((12 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((3 * CB + 7) / 8) * 8;
  localparam int LATENCY = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CB - 1));

  typedef enum logic {MODE_FORWARD = 1'b0, MODE_INVERSE = 1'b1} mode_t;
  typedef logic signed [CB-1:0] coord_t;
  // org xyz, axis xyz, plane xyz, pt xyz
  typedef coord_t point_set_t[12];
  typedef longint vec_t[3];
  typedef struct packed {
    logic [CB-1:0] rx;
    logic [CB-1:0] ry;
    logic [CB-1:0] rz;
    logic          degen;
  } frame_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_wr_data = 1'b0;

  mode_t      cur_mode = MODE_FORWARD;
  frame_res_t expected_q[$];
  int         errors = 0;
  int         n_sent = 0;
  int         n_checked = 0;
  int         n_degen = 0;
  int         cycles = 0;
  bit         sink_stalls = 1'b1;
  bit         src_gaps = 1'b1;
  int         stall_left = 0;

  always #2 clk = ~clk;

  point_local_frame_projection #(.COORD_BITS(CB)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------- predictor ----------------
  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint rnd_q16(longint v);
    longint r;
    r = longint'((magn(v) + 32768) >> 16);
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clamp(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic vec_t reduce(vec_t v, int lim);
    longint unsigned m;
    int s;
    vec_t r;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) if (magn(v[i]) > m) m = magn(v[i]);
    while ((m >> s) >= (64'd1 << lim)) s++;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'(magn(v[i]) >> s);
      if (v[i] < 0) r[i] = -r[i];
    end
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit normalise(vec_t v, output vec_t u);
    vec_t w;
    longint unsigned n2, len;
    w = reduce(v, 30);
    n2 = 0;
    for (int i = 0; i < 3; i++) n2 += magn(w[i]) * magn(w[i]);
    if (n2 == 0) return 1'b0;
    len = int_sqrt(n2);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'((magn(w[i]) * 65536 + len / 2) / len);
      if (w[i] < 0) u[i] = -u[i];
    end
    return 1'b1;
  endfunction

  function automatic vec_t cross3(vec_t x, vec_t y);
    vec_t r;
    r[0] = x[1] * y[2] - x[2] * y[1];
    r[1] = x[2] * y[0] - x[0] * y[2];
    r[2] = x[0] * y[1] - x[1] * y[0];
    return r;
  endfunction

  function automatic frame_res_t project_points(point_set_t ps, mode_t mode);
    vec_t a, p, d, e, q, v1, v2, v3, w;
    longint res[3];
    frame_res_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = ps[i];
      p[i] = ps[9 + i];
      d[i] = longint'(ps[3 + i]) - a[i];
      e[i] = longint'(ps[6 + i]) - a[i];
      q[i] = p[i] - a[i];
      res[i] = 0;
    end
    r.degen = 1'b1;
    if (normalise(d, v1)) begin
      w = cross3(reduce(d, 31), reduce(e, 31));
      if (normalise(w, v3)) begin
        r.degen = 1'b0;
        w = cross3(v3, v1);
        for (int i = 0; i < 3; i++) v2[i] = rnd_q16(w[i]);
        if (mode == MODE_FORWARD) begin
          res[0] = clamp(rnd_q16(q[0] * v1[0] + q[1] * v1[1] + q[2] * v1[2]));
          res[1] = clamp(rnd_q16(q[0] * v2[0] + q[1] * v2[1] + q[2] * v2[2]));
          res[2] = clamp(rnd_q16(q[0] * v3[0] + q[1] * v3[1] + q[2] * v3[2]));
        end else begin
          for (int i = 0; i < 3; i++)
            res[i] = clamp(rnd_q16(p[0] * v1[i] + p[1] * v2[i] + p[2] * v3[i]) + a[i]);
        end
      end
    end
    r.rx = res[0][CB-1:0];
    r.ry = res[1][CB-1:0];
    r.rz = res[2][CB-1:0];
    return r;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    frame_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h deg %b",
                 $time, out_tdata[3*CB-1:0], out_tuser);
        errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (want.degen) n_degen++;
        if (out_tdata[CB-1:0] !== want.rx) begin
          $display("%0t: res_x expected %h actual %h", $time, want.rx, out_tdata[CB-1:0]);
          errors++;
        end
        if (out_tdata[2*CB-1:CB] !== want.ry) begin
          $display("%0t: res_y expected %h actual %h", $time, want.ry, out_tdata[2*CB-1:CB]);
          errors++;
        end
        if (out_tdata[3*CB-1:2*CB] !== want.rz) begin
          $display("%0t: res_z expected %h actual %h", $time, want.rz,
                   out_tdata[3*CB-1:2*CB]);
          errors++;
        end
        if (out_tuser !== want.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degen, out_tuser);
          errors++;
        end
      end
      stall_left = sink_stalls ? $urandom_range(0, 15) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_tready <= rst_n && (stall_left == 0 || (out_tvalid && out_tready && stall_left == 0));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("point_local_frame_projection test failed");
      $finish;
    end
  end

  // ---------------- source side ----------------
  task automatic send_points(point_set_t ps);
    int gap;
    logic [IN_W-1:0] word;
    gap = src_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    for (int i = 0; i < 12; i++) word[i*CB +: CB] = ps[i];
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(project_points(ps, cur_mode));
    n_sent++;
  endtask

  // hold the source quiet until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_mode(mode_t m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = m;
  endtask

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic point_set_t mk(longint ax, longint ay, longint az, longint bx,
                                    longint by, longint bz, longint cx, longint cy,
                                    longint cz, longint px, longint py, longint pz);
    point_set_t ps;
    ps = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
           coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz), coord_t'(px),
           coord_t'(py), coord_t'(pz)};
    return ps;
  endfunction

  task automatic test_directed(mode_t m);
    set_mode(m);
    // unit axes
    send_points(mk(0, 0, 0, 10, 0, 0, 0, 7, 0, 3, 4, 5));
    send_points(mk(5, -5, 9, 5, 40, 9, 5, -5, 100, -8, 1, 2));
    // zero axis, also with every frame point coordinate at an extreme
    send_points(mk(12, 34, -56, 12, 34, -56, 1, 2, 3, 4, 5, 6));
    send_points(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0));
    // collinear plane point, and plane point equal to the origin
    send_points(mk(1, 2, 3, 4, 6, 8, 10, 14, 18, 9, 9, 9));
    send_points(mk(1, 2, 3, 4, 6, 8, 1, 2, 3, 9, 9, 9));
    // widest spans, saturation in both modes
    send_points(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX));
    send_points(mk(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN));
    send_points(mk(CMAX, CMIN, 0, CMIN, CMAX, 0, CMIN, CMIN, 0, CMAX, CMAX, CMAX));
    send_points(mk(0, 0, 0, 1, 1, 1, -1, 1, 0, CMAX, CMAX, CMAX));
    send_points(mk(0, 0, 0, 1, 0, 0, 1, 1, 0, CMIN, CMIN, CMIN));
  endtask

  task automatic test_random(int n);
    point_set_t ps;
    longint k;
    for (int t = 0; t < n; t++) begin
      // switch at random between stretches with and without idling
      if (t % 200 == 0) begin
        src_gaps = ($urandom_range(0, 2) != 0);
        sink_stalls = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: for (int i = 0; i < 12; i++) ps[i] = rnd_coord(0);
        4, 5, 6: for (int i = 0; i < 12; i++) ps[i] = rnd_coord(2000);
        7: for (int i = 0; i < 12; i++)
             ps[i] = $urandom_range(0, 1) ? coord_t'(CMAX - $urandom_range(0, 3))
                                          : coord_t'(CMIN + $urandom_range(0, 3));
        8: begin
          for (int i = 0; i < 12; i++) ps[i] = rnd_coord(0);
          for (int i = 0; i < 3; i++) ps[3 + i] = ps[i];
        end
        default: begin
          for (int i = 0; i < 12; i++) ps[i] = rnd_coord(1000);
          k = longint'($urandom_range(0, 16)) - 8;
          for (int i = 0; i < 3; i++)
            ps[6 + i] = coord_t'(ps[i] + k * (longint'(ps[3 + i]) - ps[i]));
        end
      endcase
      send_points(ps);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed(MODE_FORWARD);
    test_directed(MODE_INVERSE);
    set_mode(MODE_FORWARD);
    test_random(900);
    set_mode(MODE_INVERSE);
    test_random(900);
    set_mode(MODE_FORWARD);
    test_random(40);
    drain();
    $display("covered %0d frames in both modes, %0d results checked, %0d degenerate",
             n_sent, n_checked, n_degen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("point_local_frame_projection test passed");
    end else begin
      $display("point_local_frame_projection test failed");
    end
    $finish;
  end
endmodule
